// ===== src/dwpi_pkg.sv =====
// ----------------------------------------------------------------------------
// dwpi_pkg: shared types and constants for the dual wheel PI controller
// Fixed-point widths, sequencer operation codes, register map and the
// integral saturation helper.
// ----------------------------------------------------------------------------
package dwpi_pkg;

  // Width of the committed integral, signed Q(INTEGRAL_BITS-16).16 volts
  localparam int INTEGRAL_BITS = 32;

  localparam int SPEED_W = 16;
  localparam int DIFF_W  = SPEED_W + 1;           // ref - meas
  localparam int ERR_W   = 25;                    // gear * diff, |x| < 2^24
  localparam int TERM_W  = 41;                    // gain * err
  localparam int PROP_W  = 37;                    // proportional term / increment, Q.16
  localparam int MULB_W  = 17;                    // unsigned 16-bit operand plus sign
  localparam int MULA_W  = (INTEGRAL_BITS > TERM_W) ? INTEGRAL_BITS : TERM_W;
  localparam int PROD_W  = MULA_W + MULB_W;
  localparam int SUM_W   = ((INTEGRAL_BITS > PROP_W) ? INTEGRAL_BITS : PROP_W) + 1;
  localparam int SCL_W   = INTEGRAL_BITS + MULB_W; // volt * percent_per_volt
  localparam int CMD_W   = 8;

  localparam logic signed [SUM_W-1:0] INT_HI =
    SUM_W'({1'b0, {(INTEGRAL_BITS-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] INT_LO = ~INT_HI;

  localparam logic signed [CMD_W-1:0] CMD_POS = 8'sd100;
  localparam logic signed [CMD_W-1:0] CMD_NEG = -8'sd100;

  // Register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN        = 3'd0,
    REG_INTEGRAL_GAIN    = 3'd1,
    REG_GEAR_RATIO       = 3'd2,
    REG_VOLTAGE_LIMIT    = 3'd3,
    REG_PERCENT_PER_VOLT = 3'd4
  } reg_idx_t;

  localparam logic [15:0] RST_PROP_GAIN        = 16'd184;
  localparam logic [15:0] RST_INTEGRAL_GAIN    = 16'd848;
  localparam logic [7:0]  RST_GEAR_RATIO       = 8'd14;
  localparam logic [15:0] RST_VOLTAGE_LIMIT    = 16'd5837;
  localparam logic [15:0] RST_PERCENT_PER_VOLT = 16'd1123;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integral_gain;
    logic [7:0]  gear_ratio;
    logic [15:0] voltage_limit;
    logic [15:0] percent_per_volt;
  } cfg_t;

  // One operation per cycle, issued by the sequencer to both wheel lanes
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_PROP,
    OP_TERM,
    OP_INC,
    OP_CAND,
    OP_VOLT,
    OP_SCALE,
    OP_DONE
  } op_t;

  function automatic logic signed [INTEGRAL_BITS-1:0] sat_int(
    input logic signed [SUM_W-1:0] x
  );
    if (x > INT_HI) begin
      sat_int = INT_HI[INTEGRAL_BITS-1:0];
    end else if (x < INT_LO) begin
      sat_int = INT_LO[INTEGRAL_BITS-1:0];
    end else begin
      sat_int = x[INTEGRAL_BITS-1:0];
    end
  endfunction

endpackage

// ===== src/dwpi_cfg.sv =====
// ----------------------------------------------------------------------------
// dwpi_cfg: controller gain and limit registers
// Takes one write per cycle; indexes beyond the register map are dropped.
// ----------------------------------------------------------------------------
module dwpi_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dwpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data,
  output dwpi_pkg::cfg_t                    cfg
);
  import dwpi_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= RST_PROP_GAIN;
      cfg.integral_gain    <= RST_INTEGRAL_GAIN;
      cfg.gear_ratio       <= RST_GEAR_RATIO;
      cfg.voltage_limit    <= RST_VOLTAGE_LIMIT;
      cfg.percent_per_volt <= RST_PERCENT_PER_VOLT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROP_GAIN:        cfg.prop_gain        <= cfg_data;
        REG_INTEGRAL_GAIN:    cfg.integral_gain    <= cfg_data;
        REG_GEAR_RATIO:       cfg.gear_ratio       <= cfg_data[7:0];
        REG_VOLTAGE_LIMIT:    cfg.voltage_limit    <= cfg_data;
        REG_PERCENT_PER_VOLT: cfg.percent_per_volt <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dwpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwpi_ctrl: sequencer for the PI update
// Steps both wheel lanes through the operation list and owns the result
// valid flag; a new item is taken while an earlier result waits.
// ----------------------------------------------------------------------------
module dwpi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output dwpi_pkg::op_t  op
);
  import dwpi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_PROP,
    ST_TERM,
    ST_INC,
    ST_CAND,
    ST_VOLT,
    ST_SCALE,
    ST_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    op = OP_NONE;
    case (state)
      ST_IDLE:  if (s_tvalid) op = OP_LOAD;
      ST_ERR:   op = OP_ERR;
      ST_PROP:  op = OP_PROP;
      ST_TERM:  op = OP_TERM;
      ST_INC:   op = OP_INC;
      ST_CAND:  op = OP_CAND;
      ST_VOLT:  op = OP_VOLT;
      ST_SCALE: op = OP_SCALE;
      ST_DONE:  if (out_free) op = OP_DONE;
      default:  op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // result lands in the lane output registers on the last step
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE:  if (s_tvalid) state <= ST_ERR;
        ST_ERR:   state <= ST_PROP;
        ST_PROP:  state <= ST_TERM;
        ST_TERM:  state <= ST_INC;
        ST_INC:   state <= ST_CAND;
        ST_CAND:  state <= ST_VOLT;
        ST_VOLT:  state <= ST_SCALE;
        ST_SCALE: state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/dwpi_lane.sv =====
// ----------------------------------------------------------------------------
// dwpi_lane: PI datapath for one wheel
// One shared multiplier, operand selection by operation code, integral
// state with conditional commit, and the registered command output.
// ----------------------------------------------------------------------------
module dwpi_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dwpi_pkg::op_t                        op,
  input  dwpi_pkg::cfg_t                       cfg,
  input  logic signed [dwpi_pkg::SPEED_W-1:0]  ref_speed,
  input  logic signed [dwpi_pkg::SPEED_W-1:0]  meas_speed,
  input  logic [15:0]                          time_step,
  output logic signed [dwpi_pkg::CMD_W-1:0]    command,
  output logic                                 saturated
);
  import dwpi_pkg::*;

  localparam logic signed [SCL_W-1:0] CLAMP_HI = SCL_W'(100);
  localparam logic signed [SCL_W-1:0] CLAMP_LO = -CLAMP_HI;
  localparam logic signed [SCL_W-1:0] TRUNC_RND = SCL_W'(24'hFFFFFF);

  logic signed [DIFF_W-1:0]        diff;
  logic [15:0]                     dt;
  logic signed [ERR_W-1:0]         err;
  logic signed [PROP_W-1:0]        prop;
  logic signed [TERM_W-1:0]        term;
  logic signed [PROP_W-1:0]        inc;
  logic signed [INTEGRAL_BITS-1:0] cand;
  logic signed [INTEGRAL_BITS-1:0] volt;
  logic signed [INTEGRAL_BITS-1:0] integ;
  logic signed [SCL_W-1:0]         scaled;
  logic                            over_hi;
  logic                            over_lo;

  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  limit;
  logic signed [SUM_W-1:0]  volt_ext;
  logic signed [SCL_W-1:0]  rnd;
  logic signed [SCL_W-1:0]  quot;
  logic signed [CMD_W-1:0]  cmd_lin;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_ERR: begin
        mul_a = MULA_W'(diff);
        mul_b = {{(MULB_W-8){1'b0}}, cfg.gear_ratio};
      end
      OP_PROP: begin
        mul_a = MULA_W'(err);
        mul_b = {1'b0, cfg.prop_gain};
      end
      OP_TERM: begin
        mul_a = MULA_W'(err);
        mul_b = {1'b0, cfg.integral_gain};
      end
      OP_INC: begin
        mul_a = MULA_W'(term);
        mul_b = {1'b0, dt};
      end
      OP_SCALE: begin
        mul_a = MULA_W'(volt);
        mul_b = {1'b0, cfg.percent_per_volt};
      end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign limit    = SUM_W'({cfg.voltage_limit, 8'b0});
  assign volt_ext = SUM_W'(volt);

  // truncate toward zero: bias negatives before the arithmetic shift
  assign rnd  = scaled[SCL_W-1] ? TRUNC_RND : '0;
  assign quot = (scaled + rnd) >>> 24;

  always_comb begin
    if (quot > CLAMP_HI) begin
      cmd_lin = CMD_POS;
    end else if (quot < CLAMP_LO) begin
      cmd_lin = CMD_NEG;
    end else begin
      cmd_lin = quot[CMD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        diff <= DIFF_W'(ref_speed) - DIFF_W'(meas_speed);
        dt   <= time_step;
      end
      OP_ERR:  err  <= ERR_W'(prod);
      OP_PROP: prop <= PROP_W'(prod >>> 4);
      OP_TERM: term <= TERM_W'(prod);
      OP_INC:  inc  <= PROP_W'(prod >>> 20);
      OP_CAND: cand <= sat_int(SUM_W'(integ) + SUM_W'(inc));
      OP_VOLT: volt <= sat_int(SUM_W'(prop) + SUM_W'(cand));
      OP_SCALE: begin
        scaled  <= SCL_W'(prod);
        over_hi <= volt_ext > limit;
        over_lo <= volt_ext < -limit;
      end
      OP_DONE: begin
        if (over_hi) begin
          command   <= CMD_POS;
          saturated <= 1'b1;
        end else if (over_lo) begin
          command   <= CMD_NEG;
          saturated <= 1'b1;
        end else begin
          command   <= cmd_lin;
          saturated <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // integral only moves forward when the voltage stayed within the limit
  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (op == OP_DONE && !over_hi && !over_lo) begin
      integ <= cand;
    end
  end

endmodule

// ===== src/dual_wheel_pi_speed_controller_top.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_pi_speed_controller_top: two-wheel PI speed loop
// PI controllers with conditional-integration anti-windup for the left and
// right wheel, sharing one sequencer and one register set.
//
//  channel  dir  transaction      payload
//  s_*      in   speed sample     tdata: ref L, ref R, meas L, meas R, dt
//  m_*      out  motor command    tdata: cmd L, cmd R; tuser: sat L, sat R
//  cfg_*    in   register write   index 0..4, 16-bit data
//
//  An item is accepted, then takes eight steps in each wheel lane, those
//  that multiply sharing its single multiplier, the last writing the output
//  register. The next item is taken while that result waits on m_tready.
//  Reset (rst, synchronous) restores the gains and clears both integrals.
// ----------------------------------------------------------------------------
module dual_wheel_pi_speed_controller_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [15:0] ref_speed_left, [31:16] ref_speed_right, [47:32] meas_speed_left,
  // [63:48] meas_speed_right, [79:64] time_step
  input  logic [79:0]                    s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] command_left, [15:8] command_right
  output logic [15:0]                    m_tdata,
  // [0] saturated_left, [1] saturated_right
  output logic [1:0]                     m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dwpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import dwpi_pkg::*;

  cfg_t cfg;
  op_t  op;
  logic signed [CMD_W-1:0] command_left;
  logic signed [CMD_W-1:0] command_right;
  logic saturated_left;
  logic saturated_right;

  dwpi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dwpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .op       (op)
  );

  dwpi_lane u_left (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .cfg        (cfg),
    .ref_speed  (s_tdata[15:0]),
    .meas_speed (s_tdata[47:32]),
    .time_step  (s_tdata[79:64]),
    .command    (command_left),
    .saturated  (saturated_left)
  );

  dwpi_lane u_right (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .cfg        (cfg),
    .ref_speed  (s_tdata[31:16]),
    .meas_speed (s_tdata[63:48]),
    .time_step  (s_tdata[79:64]),
    .command    (command_right),
    .saturated  (saturated_right)
  );

  assign m_tdata = {command_right, command_left};
  assign m_tuser = {saturated_right, saturated_left};

  // a clipped wheel always reports full scale
  a_sat_left_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && saturated_left |-> command_left == CMD_POS || command_left == CMD_NEG)
    else $error("left saturated without full-scale command");

  a_sat_right_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && saturated_right |-> command_right == CMD_POS || command_right == CMD_NEG)
    else $error("right saturated without full-scale command");

  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> command_left >= CMD_NEG && command_left <= CMD_POS
              && command_right >= CMD_NEG && command_right <= CMD_POS)
    else $error("command outside percent range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while an item is in work");

endmodule
